// ===== rtl/sitoa_pkg.sv =====
// Shared types, constants and the digit-to-ASCII mapping for the integer-to-text block.
package sitoa_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned RADIX_W = 6;
	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned LEN_W   = 6;
	localparam int unsigned BITS_W  = 5;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] DIGIT_NINE  = 6'd9;
	localparam logic [RADIX_W-1:0] DIGIT_TEN   = 6'd10;

	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h41;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;        // capture sign and magnitude of a new request
		logic wr_zero;     // store a single zero digit
		logic div_start;   // clear the partial remainder and bit counter
		logic div_step;    // one restoring division step
		logic wr_digit;    // store the remainder, advance the digit count
		logic emit_init;   // point the emit pointer at the top digit
		logic emit_sign;   // load '-' into the output register
		logic emit_digit;  // load the next digit into the output register
		logic emit_term;   // load the terminator into the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic quot_zero;   // remaining quotient is zero
		logic cnt_zero;    // no digit stored yet
		logic cnt_at_cap;  // digit count reached the cap
		logic bits_last;   // the current division step is the last one
		logic negative;    // the request value is negative
		logic ptr_zero;    // every digit has been emitted
		logic out_free;    // the output register can take a new character
	} sts_t;

	// Map one digit to its ASCII byte: 0..9 as digits, 10..35 as upper-case letters.
	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] res;
		if (d > DIGIT_NINE) begin
			res = CHAR_UPPER + {2'b00, d - DIGIT_TEN};
		end else begin
			res = CHAR_ZERO + {2'b00, d};
		end
		return res;
	endfunction

endpackage

// ===== rtl/signed_integer_to_ascii_radix_core.sv =====
// Top level: signed 32-bit integer to ASCII text in a configurable radix.
// Conversion: each digit takes a check, 32 divide steps and a store; the characters then
// follow, a '-' first if negative, one character per cycle while the output register is free,
// with an idle state before the terminator.
// One value at a time: the next request is taken only after the terminator is loaded.
// Reset (arst_n low, asynchronous): radix 10, controller idle, output empty, store not cleared.
module signed_integer_to_ascii_radix_core import sitoa_pkg::*; #(
	parameter int unsigned MAX_DIGITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [RADIX_W-1:0]        cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [CHAR_W-1:0]         character,
	output logic [LEN_W-1:0]          string_length,
	output logic                      last
);

	cmd_t cmd;
	sts_t sts;

	// Sequencer.
	sitoa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Arithmetic, storage and output register.
	sitoa_dp #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.value         (value),
		.out_ready     (out_ready),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.character     (character),
		.string_length (string_length),
		.last          (last)
	);

endmodule

// ===== rtl/sitoa_dp.sv =====
// Datapath: radix register, serial divider, digit store, emit pointer and output register.
module sitoa_dp import sitoa_pkg::*; #(
	parameter int unsigned MAX_DIGITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [RADIX_W-1:0]  cfg_wr_data,
	input  logic signed [VALUE_W-1:0] value,
	input  logic                out_ready,
	input  cmd_t                cmd,
	output sts_t                sts,
	output logic                out_valid,
	output logic [CHAR_W-1:0]   character,
	output logic [LEN_W-1:0]    string_length,
	output logic                last
);

	localparam int unsigned IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam logic [LEN_W-1:0] CAP = LEN_W'(MAX_DIGITS);

	logic [RADIX_W-1:0] radix_q;
	logic [VALUE_W-1:0] quot_q;
	logic [RADIX_W-1:0] rem_q;
	logic [BITS_W-1:0]  bit_cnt_q;
	logic [LEN_W-1:0]   cnt_q;
	logic [LEN_W-1:0]   ptr_q;
	logic               neg_q;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  char_q;
	logic [LEN_W-1:0]   len_q;
	logic               last_q;
	logic [RADIX_W-1:0] store_q [MAX_DIGITS];

	logic [RADIX_W-1:0] base;
	logic [RADIX_W:0]   trial;
	logic               take;
	logic [LEN_W-1:0]   ptr_m1;
	logic [LEN_W-1:0]   len_now;

	// Clamp the configured radix into the supported range.
	always_comb begin
		priority if (radix_q < RADIX_MIN) begin
			base = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			base = RADIX_MAX;
		end else begin
			base = radix_q;
		end
	end

	// One restoring division step: shift the next dividend bit into the remainder.
	assign trial   = {rem_q, quot_q[VALUE_W-1]};
	assign take    = trial >= {1'b0, base};
	assign ptr_m1  = ptr_q - LEN_W'(1);
	assign len_now = cnt_q + LEN_W'(1) + {{(LEN_W-1){1'b0}}, neg_q};

	// Control and arithmetic registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q     <= RADIX_RESET;
			quot_q      <= '0;
			rem_q       <= '0;
			bit_cnt_q   <= '0;
			cnt_q       <= '0;
			ptr_q       <= '0;
			neg_q       <= 1'b0;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				radix_q <= cfg_wr_data;
			end
			if (cmd.load) begin
				neg_q  <= value[VALUE_W-1];
				quot_q <= value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(value)) : VALUE_W'(value);
				cnt_q  <= '0;
			end
			if (cmd.wr_zero) begin
				cnt_q <= LEN_W'(1);
			end
			if (cmd.div_start) begin
				rem_q     <= '0;
				bit_cnt_q <= '0;
			end
			if (cmd.div_step) begin
				rem_q     <= take ? RADIX_W'(trial - {1'b0, base}) : trial[RADIX_W-1:0];
				quot_q    <= {quot_q[VALUE_W-2:0], take};
				bit_cnt_q <= bit_cnt_q + BITS_W'(1);
			end
			if (cmd.wr_digit) begin
				cnt_q <= cnt_q + LEN_W'(1);
			end
			if (cmd.emit_init) begin
				ptr_q <= cnt_q;
			end
			if (cmd.emit_digit) begin
				ptr_q <= ptr_m1;
			end
			// Output register: hold until taken, reload on any emit command.
			if (cmd.emit_sign || cmd.emit_digit || cmd.emit_term) begin
				out_valid_q <= 1'b1;
				last_q      <= cmd.emit_term;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Digit store and output payload, no reset needed.
	always_ff @(posedge clk) begin
		if (cmd.wr_zero) begin
			store_q[cnt_q[IDX_W-1:0]] <= '0;
		end else if (cmd.wr_digit) begin
			store_q[cnt_q[IDX_W-1:0]] <= rem_q;
		end
		if (cmd.emit_sign) begin
			char_q <= CHAR_MINUS;
			len_q  <= len_now;
		end else if (cmd.emit_digit) begin
			char_q <= digit_to_ascii(store_q[ptr_m1[IDX_W-1:0]]);
			len_q  <= len_now;
		end else if (cmd.emit_term) begin
			char_q <= CHAR_NUL;
			len_q  <= len_now;
		end
	end

	// Status toward the controller.
	always_comb begin
		sts.quot_zero  = (quot_q == '0);
		sts.cnt_zero   = (cnt_q == '0);
		sts.cnt_at_cap = (cnt_q >= CAP);
		sts.bits_last  = (bit_cnt_q == {BITS_W{1'b1}});
		sts.negative   = neg_q;
		sts.ptr_zero   = (ptr_q == '0);
		sts.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid     = out_valid_q;
	assign character     = char_q;
	assign string_length = len_q;
	assign last          = last_q;

	// The digit count never passes the cap.
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CAP)
		else $error("digit count exceeds cap");

	// While dividing, the partial remainder stays below the effective base.
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (rem_q < base))
		else $error("partial remainder out of range");

	// A terminator carries a NUL byte and a length of at least two.
	a_term: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> (char_q == CHAR_NUL && len_q >= LEN_W'(2)))
		else $error("malformed terminator");

endmodule

// ===== rtl/sitoa_ctrl.sv =====
// Controller state machine sequencing division, digit storage and character emission.
module sitoa_ctrl import sitoa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_WRITE = 3'd3;
	localparam logic [2:0] ST_SIGN  = 3'd4;
	localparam logic [2:0] ST_DIGIT = 3'd5;
	localparam logic [2:0] ST_TERM  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				priority if (sts.quot_zero && sts.cnt_zero) begin
					cmd.wr_zero = 1'b1;
				end else if (!sts.quot_zero && !sts.cnt_at_cap) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end else begin
					cmd.emit_init = 1'b1;
					state_d       = ST_SIGN;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.bits_last) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				cmd.wr_digit = 1'b1;
				state_d      = ST_CHECK;
			end
			ST_SIGN: begin
				if (!sts.negative) begin
					state_d = ST_DIGIT;
				end else if (sts.out_free) begin
					cmd.emit_sign = 1'b1;
					state_d       = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				if (sts.ptr_zero) begin
					state_d = ST_TERM;
				end else if (sts.out_free) begin
					cmd.emit_digit = 1'b1;
				end
			end
			ST_TERM: begin
				if (sts.out_free) begin
					cmd.emit_term = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
